@@ src/pvm_pkg.sv @@
// Shared types and codes for the polyphonic sample voice mixer.
// Used by the controller, the datapath and the top level.
package pvm_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_TRIGGER = 2'd1;
	localparam logic [1:0] ACT_STOP    = 2'd2;
	localparam logic [1:0] ACT_TICK    = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_UNLOADED = 2'd1;
	localparam logic [1:0] ST_NO_SLOT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_LIMIT = 2'd1;

	localparam logic [14:0] FADE_LENGTH_RST = 15'd1764;
	localparam logic [5:0]  VOICE_LIMIT_RST = 6'd21;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic set_unloaded;
		logic idx_inc;
		logic idx_pick;
		logic steal_scan;
		logic steal_fade;
		logic alloc;
		logic stop_step;
		logic tick_issue;
		logic tick_mul;
		logic tick_acc;
		logic result_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_slot;
		logic trig_bad;
		logic steal_needed;
		logic tick_skip;
		logic tick_fading;
		logic div_done;
	} sts_t;

endpackage

@@ src/pvm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/pvm_div.sv @@
// Restoring divider for the fade gain: |sample * gain| / span, 16 quotient bits.
// One quotient bit per cycle. No dependencies.
module pvm_div #(
	parameter int LW = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [16+LW-1:0]   dividend,
	input  logic [LW-1:0]      divisor,
	input  logic               neg,
	output logic               done,
	output logic signed [15:0] quotient
);
	logic [LW-1:0] rem_q;
	logic [LW-1:0] dvs_q;
	logic [15:0]   dvd_q;
	logic [15:0]   quo_q;
	logic [3:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [LW:0]   trial;
	logic          ge;

	assign trial = {rem_q, dvd_q[15]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient never exceeds 16 bits, so the top part is already below the divisor
			rem_q <= dividend[16+LW-1:16];
			dvd_q <= dividend[15:0];
			dvs_q <= divisor;
			neg_q <= neg;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? LW'(trial - {1'b0, dvs_q}) : LW'(trial);
			dvd_q <= {dvd_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? 16'(-{1'b0, quo_q}) : quo_q;
endmodule

@@ src/pvm_ctrl.sv @@
// Sequencer for the voice mixer: decodes the request and walks the voice slots.
// Depends on pvm_pkg.
module pvm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_action,
	output logic          out_valid,
	input  logic          out_ready,
	output pvm_pkg::cmd_t cmd,
	input  pvm_pkg::sts_t sts
);
	import pvm_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_LOAD  = 12'b000000000010,
		S_TRIG  = 12'b000000000100,
		S_STEAL = 12'b000000001000,
		S_SFADE = 12'b000000010000,
		S_ALLOC = 12'b000000100000,
		S_STOP  = 12'b000001000000,
		S_TRD   = 12'b000010000000,
		S_TWAIT = 12'b000100000000,
		S_TDIV  = 12'b001000000000,
		S_TACC  = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (in_action)
						ACT_LOAD:    state_d = S_LOAD;
						ACT_TRIGGER: state_d = S_TRIG;
						ACT_STOP:    state_d = S_STOP;
						ACT_TICK:    state_d = S_TRD;
						default:     state_d = S_LOAD;
					endcase
				end
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_TRIG: begin
				if (sts.trig_bad) begin
					cmd.set_unloaded = 1'b1;
					state_d          = S_DONE;
				end else if (sts.steal_needed) begin
					state_d = S_STEAL;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_STEAL: begin
				cmd.steal_scan = 1'b1;
				if (sts.last_slot) begin
					cmd.idx_pick = 1'b1;
					state_d      = S_SFADE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SFADE: begin
				cmd.steal_fade = 1'b1;
				state_d        = S_ALLOC;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_DONE;
			end
			S_STOP: begin
				cmd.stop_step = 1'b1;
				if (sts.last_slot) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TRD: begin
				cmd.tick_issue = 1'b1;
				if (!sts.tick_skip) begin
					state_d = S_TWAIT;
				end else if (sts.last_slot) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TWAIT: begin
				cmd.tick_mul = 1'b1;
				state_d      = sts.tick_fading ? S_TDIV : S_TACC;
			end
			S_TDIV: begin
				if (sts.div_done) begin
					state_d = S_TACC;
				end
			end
			S_TACC: begin
				cmd.tick_acc = 1'b1;
				if (sts.last_slot) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_TRD;
				end
			end
			S_DONE: begin
				cmd.result_load = 1'b1;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ src/pvm_dp.sv @@
// Datapath: sample store, bar lengths, voice slot registers, mixer and result register.
// Depends on pvm_pkg, pvm_ram and pvm_div.
module pvm_dp #(
	parameter int BARS        = 32,
	parameter int BAR_SAMPLES = 16384,
	parameter int VOICE_SLOTS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pvm_pkg::cmd_t                cmd,
	output pvm_pkg::sts_t                sts,
	input  logic [1:0]                   in_action,
	input  logic [4:0]                   in_bar,
	input  logic [13:0]                  in_addr,
	input  logic signed [15:0]           in_sample,
	input  logic                         in_last,
	input  logic                         cfg_we,
	input  logic [pvm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pvm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [pvm_pkg::OUT_TDATA_W-1:0] result
);
	import pvm_pkg::*;

	localparam int BW    = (BARS > 1) ? $clog2(BARS) : 1;
	localparam int SW    = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int CW    = $clog2(VOICE_SLOTS + 1);
	localparam int LW    = $clog2(BAR_SAMPLES + 1);
	localparam int XW    = (LW > 15) ? LW : 15;
	localparam int DEPTH = BARS * BAR_SAMPLES;
	localparam int RA    = $clog2(DEPTH);
	localparam int SUMW  = 17 + SW;

	// config
	logic [14:0] fade_len_q;
	logic [5:0]  limit_q;

	// captured request
	logic [1:0]         action_q;
	logic [4:0]         bar_q;
	logic [13:0]        addr_q;
	logic signed [15:0] sample_q;
	logic               last_q;

	// voice slots
	logic [BARS-1:0][LW-1:0]        bar_len_q;
	logic [VOICE_SLOTS-1:0]         active_q;
	logic [VOICE_SLOTS-1:0]         fading_q;
	logic [VOICE_SLOTS-1:0][BW-1:0] vbar_q;
	logic [VOICE_SLOTS-1:0][LW-1:0] pos_q;
	logic [VOICE_SLOTS-1:0][LW-1:0] fstart_q;
	logic [VOICE_SLOTS-1:0][LW-1:0] span_q;
	logic [CW-1:0]                  count_q;

	logic [SW-1:0]          idx_q;
	logic [SW-1:0]          pick_q;
	logic                   pick_ok_q;
	logic [LW-1:0]          best_q;
	logic [1:0]             status_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [15:0]     smp_q;

	logic [BW-1:0] bi;
	logic          act, fad, rem_zero, fdone;
	logic [BW-1:0] vb;
	logic [LW-1:0] pos, len, rem, f, gain, span_new;
	logic [LW:0]   pos_inc;
	logic          free_ok;
	logic [SW-1:0] free_idx;
	logic          steal_hit;

	logic          ram_we;
	logic [RA-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_rdata;

	logic               div_start, div_done;
	logic [15:0]        mag;
	logic [16+LW-1:0]   product;
	logic signed [15:0] quot;

	logic signed [SUMW+1:0] scaled;
	logic signed [SUMW+1:0] shifted;
	logic signed [15:0]     mix;
	logic                   clip;

	assign bi       = BW'(bar_q);
	assign act      = active_q[idx_q];
	assign fad      = fading_q[idx_q];
	assign vb       = vbar_q[idx_q];
	assign pos      = pos_q[idx_q];
	assign len      = bar_len_q[vb];
	assign rem_zero = len <= pos;
	assign rem      = rem_zero ? '0 : len - pos;
	assign f        = pos - fstart_q[idx_q];
	assign fdone    = f >= span_q[idx_q];
	assign gain     = span_q[idx_q] - f;
	assign span_new = (XW'(fade_len_q) < XW'(rem)) ? LW'(fade_len_q) : rem;
	assign pos_inc  = {1'b0, pos} + 1'b1;
	// strict compare keeps the lowest slot on ties
	assign steal_hit = cmd.steal_scan && act && !fad && (pos > best_q);

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int s = VOICE_SLOTS - 1; s >= 0; s--) begin
			if (!active_q[s]) begin
				free_ok  = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	assign sts.last_slot    = idx_q == SW'(VOICE_SLOTS - 1);
	assign sts.trig_bad     = (32'(bar_q) >= BARS) || (bar_len_q[bi] == '0);
	assign sts.steal_needed = 32'(count_q) >= 32'(limit_q);
	assign sts.tick_skip    = !act || rem_zero || (fad && fdone);
	assign sts.tick_fading  = fad;
	assign sts.div_done     = div_done;

	// sample store
	assign ram_we    = cmd.load_wr && (32'(bar_q) < BARS) && (32'(addr_q) < BAR_SAMPLES);
	assign ram_waddr = RA'(32'(bi) * BAR_SAMPLES + 32'(addr_q));
	assign ram_raddr = RA'(32'(vb) * BAR_SAMPLES + 32'(pos));

	pvm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// fade gain: sample * (span - f) / span, truncated toward zero
	assign mag       = ram_rdata[15] ? 16'(-ram_rdata) : ram_rdata;
	assign product   = (16+LW)'(mag) * (16+LW)'(gain);
	assign div_start = cmd.tick_mul && fad;

	pvm_div #(.LW(LW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (span_q[idx_q]),
		.neg      (ram_rdata[15]),
		.done     (div_done),
		.quotient (quot)
	);

	// x3/4 with floor, then saturate
	assign scaled  = (SUMW+2)'(sum_q) * (SUMW+2)'(3);
	assign shifted = scaled >>> 2;
	always_comb begin
		clip = 1'b1;
		if (shifted > 32767) begin
			mix = 16'sh7FFF;
		end else if (shifted < -32768) begin
			mix = -16'sh8000;
		end else begin
			mix  = 16'(shifted);
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_len_q <= FADE_LENGTH_RST;
			limit_q    <= VOICE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_FADE_LENGTH) begin
				fade_len_q <= cfg_data[14:0];
			end else if (cfg_idx == REG_VOICE_LIMIT) begin
				limit_q <= cfg_data[5:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			bar_q    <= in_bar;
			addr_q   <= in_addr;
			sample_q <= in_sample;
			last_q   <= in_last;
		end
		if (cmd.tick_mul) begin
			smp_q <= ram_rdata;
		end
		if (cmd.result_load) begin
			result <= {7'd0, 6'(count_q), status_q,
				(action_q == ACT_TICK) && clip,
				(action_q == ACT_TICK) ? mix : 16'sd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_len_q <= '0;
			active_q  <= '0;
			fading_q  <= '0;
			vbar_q    <= '0;
			pos_q     <= '0;
			fstart_q  <= '0;
			span_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			pick_q    <= '0;
			pick_ok_q <= 1'b0;
			best_q    <= '0;
			status_q  <= ST_DONE;
			sum_q     <= '0;
		end else begin
			if (cmd.capture) begin
				idx_q     <= '0;
				pick_ok_q <= 1'b0;
				best_q    <= '0;
				status_q  <= ST_DONE;
				sum_q     <= '0;
			end else if (cmd.idx_pick) begin
				// the last slot can win the scan in this same cycle
				idx_q <= steal_hit ? idx_q : pick_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end

			if (ram_we && last_q) begin
				bar_len_q[bi] <= LW'(32'(addr_q) + 1);
			end
			if (cmd.set_unloaded) begin
				status_q <= ST_UNLOADED;
			end

			if (steal_hit) begin
				best_q    <= pos;
				pick_q    <= idx_q;
				pick_ok_q <= 1'b1;
			end

			if ((cmd.steal_fade && pick_ok_q) ||
			    (cmd.stop_step && act && !fad && !rem_zero)) begin
				fading_q[idx_q] <= 1'b1;
				fstart_q[idx_q] <= pos;
				span_q[idx_q]   <= span_new;
				if (span_new == '0) begin
					active_q[idx_q] <= 1'b0;
					count_q         <= count_q - 1'b1;
				end
			end

			if (cmd.alloc) begin
				if (free_ok) begin
					active_q[free_idx] <= 1'b1;
					fading_q[free_idx] <= 1'b0;
					vbar_q[free_idx]   <= bi;
					pos_q[free_idx]    <= '0;
					fstart_q[free_idx] <= '0;
					span_q[free_idx]   <= '0;
					count_q            <= count_q + 1'b1;
				end else begin
					status_q <= ST_NO_SLOT;
				end
			end

			if (cmd.tick_issue && act && sts.tick_skip) begin
				active_q[idx_q] <= 1'b0;
				count_q         <= count_q - 1'b1;
			end

			if (cmd.tick_acc) begin
				sum_q        <= sum_q + SUMW'(fad ? quot : smp_q);
				pos_q[idx_q] <= LW'(pos_inc);
				if (!fad && pos_inc >= {1'b0, len}) begin
					active_q[idx_q] <= 1'b0;
					count_q         <= count_q - 1'b1;
				end
			end
		end
	end
endmodule

@@ src/polyphonic_sample_voice_mixer.sv @@
// Top level of the polyphonic sample voice mixer: ports, controller and datapath.
// Depends on pvm_pkg, pvm_ctrl and pvm_dp.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: action, bar, load_address, sample_value; tlast
//  m_axis    out  m_axis_tvalid/tready   tdata: mix_sample, clipped, status, voices_active
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request at a time. Load writes the sample store and Stop walks every slot.
// Trigger runs the steal scan, which walks every slot, only when a steal is needed.
// Tick visits every slot; a fading slot waits on the 16-step divider. Reset clears
// all voices and bar lengths at once. A waiting result in the output register blocks
// the next request only until taken.
module polyphonic_sample_voice_mixer #(
	parameter int BARS        = 32,
	parameter int BAR_SAMPLES = 16384,
	parameter int VOICE_SLOTS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// action[1:0], bar[6:2], load_address[20:7], sample_value[36:21], zero pad
	input  logic [pvm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// mix_sample[15:0], clipped[16], status[18:17], voices_active[24:19], zero pad
	output logic [pvm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pvm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pvm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pvm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tdata[1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pvm_dp #(
		.BARS        (BARS),
		.BAR_SAMPLES (BAR_SAMPLES),
		.VOICE_SLOTS (VOICE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_action (s_axis_tdata[1:0]),
		.in_bar    (s_axis_tdata[6:2]),
		.in_addr   (s_axis_tdata[20:7]),
		.in_sample (s_axis_tdata[36:21]),
		.in_last   (s_axis_tlast),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_data  (cfg_data),
		.result    (m_axis_tdata)
	);
endmodule

@@ verif/polyphonic_sample_voice_mixer_tb.sv @@
// Testbench for polyphonic_sample_voice_mixer: a directed table, then random phases
// at several register settings, each result checked against an in-bench predictor.
// Depends on pvm_pkg and the mixer RTL only.
module polyphonic_sample_voice_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pvm_pkg::*;

	localparam int NBARS     = 32;
	localparam int BAR_WORDS = 16384;
	localparam int NSLOTS    = 32;
	localparam int CYC_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]         act;
		logic [4:0]         bar;
		logic [13:0]        addr;
		logic signed [15:0] val;
		logic               last;
	} req_t;

	typedef struct packed {
		logic signed [15:0] mix;
		logic               clip;
		logic [1:0]         st;
		logic [5:0]         nv;
	} mix_res_t;

	typedef struct packed {
		req_t     rq;
		logic     chk;
		mix_res_t want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	polyphonic_sample_voice_mixer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---- predictor state ----
	logic signed [15:0] words[int];
	int                 bar_len[NBARS];
	bit                 v_on[NSLOTS];
	bit                 v_fade[NSLOTS];
	int                 v_bar[NSLOTS];
	int                 v_pos[NSLOTS];
	int                 v_fstart[NSLOTS];
	int                 v_span[NSLOTS];
	int                 fade_len = FADE_LENGTH_RST;
	int                 vlimit = VOICE_LIMIT_RST;

	mix_res_t mix_expect_q[$];
	int       errors = 0;
	int       cyc = 0;

	// stimulus side view of what has been written, so no unwritten word is ever played
	bit gen_written[int];
	int gen_filled[NBARS];
	int gen_len[NBARS];
	int burst_left = 0;
	bit sender_idles = 1'b1;

	function automatic int words_left(int s);
		return bar_len[v_bar[s]] > v_pos[s] ? bar_len[v_bar[s]] - v_pos[s] : 0;
	endfunction

	function automatic void begin_fade(int s);
		int r;
		r = words_left(s);
		v_fade[s] = 1'b1;
		v_fstart[s] = v_pos[s];
		v_span[s] = fade_len < r ? fade_len : r;
		if (v_span[s] == 0) v_on[s] = 1'b0;
	endfunction

	function automatic mix_res_t mixer_step(req_t rq);
		mix_res_t r;
		int       n, pick, slot, best;
		longint   acc, smp, t, q, f;
		r = '0;
		if (rq.act == ACT_LOAD) begin
			words[rq.bar * BAR_WORDS + rq.addr] = rq.val;
			if (rq.last) bar_len[rq.bar] = rq.addr + 1;
		end else if (rq.act == ACT_TRIGGER) begin
			if (bar_len[rq.bar] == 0) begin
				r.st = ST_UNLOADED;
			end else begin
				n = 0;
				foreach (v_on[s]) if (v_on[s]) n++;
				if (n >= vlimit) begin
					pick = -1;
					best = 0;
					foreach (v_on[s])
						if (v_on[s] && !v_fade[s] && v_pos[s] > best) begin
							best = v_pos[s];
							pick = s;
						end
					if (pick >= 0) begin_fade(pick);
				end
				slot = -1;
				for (int s = 0; s < NSLOTS; s++)
					if (!v_on[s]) begin
						slot = s;
						break;
					end
				if (slot < 0) begin
					r.st = ST_NO_SLOT;
				end else begin
					v_on[slot] = 1'b1;
					v_fade[slot] = 1'b0;
					v_bar[slot] = rq.bar;
					v_pos[slot] = 0;
					v_fstart[slot] = 0;
					v_span[slot] = 0;
				end
			end
		end else if (rq.act == ACT_STOP) begin
			foreach (v_on[s])
				if (v_on[s] && !v_fade[s] && words_left(s) > 0) begin_fade(s);
		end else begin
			acc = 0;
			foreach (v_on[s]) begin
				if (!v_on[s]) continue;
				if (words_left(s) == 0) begin
					v_on[s] = 1'b0;
					continue;
				end
				smp = words[v_bar[s] * BAR_WORDS + v_pos[s]];
				if (v_fade[s]) begin
					f = v_pos[s] - v_fstart[s];
					if (f >= v_span[s]) begin
						v_on[s] = 1'b0;
						continue;
					end
					smp = smp * (v_span[s] - f) / v_span[s];
				end
				acc += smp;
				v_pos[s]++;
				if (v_pos[s] >= bar_len[v_bar[s]] && !v_fade[s]) v_on[s] = 1'b0;
			end
			t = acc * 3;
			q = t >>> 2;
			if (q > 32767) begin
				q = 32767;
				r.clip = 1'b1;
			end else if (q < -32768) begin
				q = -32768;
				r.clip = 1'b1;
			end
			r.mix = q[15:0];
		end
		n = 0;
		foreach (v_on[s]) if (v_on[s]) n++;
		r.nv = 6'(n);
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("[%0d] mismatch %s: got %0d, expected %0d", cyc, what, got, want);
		errors++;
	endtask

	// requests and config are decided at the negedge before the accepting edge
	always @(negedge clk) begin
		mix_res_t got, want;
		req_t     rq;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FADE_LENGTH) fade_len = cfg_data[14:0];
				else if (cfg_index == REG_VOICE_LIMIT) vlimit = cfg_data[5:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				rq.act = s_axis_tdata[1:0];
				rq.bar = s_axis_tdata[6:2];
				rq.addr = s_axis_tdata[20:7];
				rq.val = s_axis_tdata[36:21];
				rq.last = s_axis_tlast;
				mix_expect_q.insert(mix_expect_q.size(), mixer_step(rq));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[18:17],
					m_axis_tdata[24:19]};
				if (mix_expect_q.size() == 0) begin
					report("unexpected result, tdata", m_axis_tdata, 0);
				end else begin
					want = mix_expect_q.pop_front();
					if (got.mix != want.mix) report("mix_sample", got.mix, want.mix);
					if (got.clip != want.clip) report("clipped", got.clip, want.clip);
					if (got.st != want.st) report("status", got.st, want.st);
					if (got.nv != want.nv) report("voices_active", got.nv, want.nv);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYC_LIMIT) begin
			$display("** polyphonic_sample_voice_mixer: FAILED **");
			$finish;
		end
	end

	// receiver: random ready runs, plus one long hold-off to back up the block
	initial begin
		int run, rx_cyc;
		bit rdy;
		run = 0;
		rx_cyc = 0;
		rdy = 1'b1;
		forever begin
			@(posedge clk);
			rx_cyc++;
			if (rx_cyc >= 6000 && rx_cyc < 6600) begin
				m_axis_tready <= 1'b0;
			end else begin
				if (run == 0) begin
					run = $urandom_range(1, 20);
					rdy = $urandom_range(0, 3) != 0;
				end
				run--;
				m_axis_tready <= rdy;
			end
		end
	end

	task automatic send(req_t rq);
		int  g, k;
		bit  rdy;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			g = sender_idles ? $urandom_range(0, 6) : 0;
			if (g > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, rq.val, rq.addr, rq.bar, rq.act};
		s_axis_tlast <= rq.last;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		if (rq.act == ACT_LOAD) begin
			gen_written[rq.bar * BAR_WORDS + rq.addr] = 1'b1;
			k = rq.bar * BAR_WORDS;
			while (gen_filled[rq.bar] < BAR_WORDS && gen_written.exists(k + gen_filled[rq.bar]))
				gen_filled[rq.bar]++;
			if (rq.last) gen_len[rq.bar] = rq.addr + 1;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		bit rdy;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (mix_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t mk(logic [1:0] a, int b, int ad, int v, bit l);
		req_t r;
		r.act = a;
		r.bar = 5'(b);
		r.addr = 14'(ad);
		r.val = 16'(v);
		r.last = l;
		return r;
	endfunction

	// one random step: mostly well-formed bar loads, triggers and ticks, some noise
	task automatic random_step(int trig_burst);
		int    r, b, n, cnt;
		req_t  rq;
		r = $urandom_range(0, 99);
		b = $urandom_range(0, NBARS - 1);
		if (trig_burst > 0) begin
			for (int i = 0; i < trig_burst; i++) begin
				b = 0;
				while (gen_len[b] == 0) b++;
				send(mk(ACT_TRIGGER, b, $urandom, $urandom, $urandom_range(0, 1)));
			end
		end else if (r < 8) begin
			n = $urandom_range(0, 3) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send(mk(ACT_LOAD, b, i, $urandom, i == n - 1));
		end else if (r < 14 && gen_filled[b] > 0) begin
			// reload with a new length, possibly shorter than playing positions
			send(mk(ACT_LOAD, b, $urandom_range(0, gen_filled[b] - 1), $urandom, 1'b1));
		end else if (r < 20) begin
			send(mk(ACT_LOAD, b, $urandom_range(0, BAR_WORDS - 1), $urandom, 1'b0));
		end else if (r < 45) begin
			cnt = 0;
			while (gen_len[b] == 0 && cnt < NBARS) begin
				b = (b + 1) % NBARS;
				cnt++;
			end
			send(mk(ACT_TRIGGER, b, $urandom, $urandom, $urandom_range(0, 1)));
		end else if (r < 50) begin
			send(mk(ACT_TRIGGER, b, $urandom, $urandom, 1'b0));
		end else if (r < 55) begin
			send(mk(ACT_STOP, b, $urandom, $urandom, 1'b0));
		end else begin
			send(mk(ACT_TICK, b, $urandom, $urandom, 1'b0));
		end
	endtask

	row_t dir_rows[25];
	int   fade_set[7] = '{1764, 0, 16384, 3, 5, 1, 40};
	int   limit_set[7] = '{21, 1, 32, 0, 63, 2, 4};

	initial begin
		mix_res_t got_row;
		dir_rows = '{
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_STOP, 0, 0, 0, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_TRIGGER, 0, 0, 0, 0), 1'b1, '{16'sd0, 1'b0, ST_UNLOADED, 6'd0}},
			'{mk(ACT_TRIGGER, 31, 0, 0, 0), 1'b1, '{16'sd0, 1'b0, ST_UNLOADED, 6'd0}},
			'{mk(ACT_LOAD, 0, 0, 32767, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_LOAD, 0, 1, -32768, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_LOAD, 0, 2, 16'h1234, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_LOAD, 0, 3, -1, 1), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_LOAD, 31, 16383, -1, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd0}},
			'{mk(ACT_TRIGGER, 0, 0, 0, 0), 1'b1, '{16'sd0, 1'b0, ST_DONE, 6'd1}},
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b1, '{16'sd24575, 1'b0, ST_DONE, 6'd1}},
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b1, '{-16'sd24576, 1'b0, ST_DONE, 6'd1}},
			'{mk(ACT_LOAD, 1, 0, 32767, 1), 1'b0, '0},
			'{mk(ACT_TRIGGER, 1, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TRIGGER, 1, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TRIGGER, 1, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_LOAD, 2, 0, -32768, 1), 1'b0, '0},
			'{mk(ACT_TRIGGER, 2, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TRIGGER, 2, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TRIGGER, 2, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TRIGGER, 0, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_STOP, 0, 0, 0, 0), 1'b0, '0},
			'{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].rq);
			if (dir_rows[i].chk) begin
				// the predictor must agree with the hand values too
				got_row = mix_expect_q[mix_expect_q.size() - 1];
				if (got_row != dir_rows[i].want) report("table row", i, i);
			end
		end

		foreach (fade_set[p]) begin
			write_reg(REG_FADE_LENGTH, fade_set[p]);
			write_reg(REG_VOICE_LIMIT, limit_set[p]);
			sender_idles = p != 2;
			for (int i = 0; i < 32; i++)
				random_step(0);
			// a trigger storm without ticks fills every slot
			if (limit_set[p] == 63) random_step(34);
		end

		s_axis_tvalid <= 1'b0;
		while (mix_expect_q.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (mix_expect_q.size() != 0) report("results still owed", 0, mix_expect_q.size());
		if (errors == 0) begin
			$display("** polyphonic_sample_voice_mixer: PASSED **");
		end else begin
			$display("** polyphonic_sample_voice_mixer: FAILED **");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
src/pvm_pkg.sv
src/pvm_ram.sv
src/pvm_div.sv
src/pvm_ctrl.sv
src/pvm_dp.sv
src/polyphonic_sample_voice_mixer.sv
verif/polyphonic_sample_voice_mixer_tb.sv
